### rtl/mrrim_pkg.sv
// Package for the multi-reader ring index manager: sizes, codes and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrrim_pkg;
   localparam int RING_DEPTH = 256;
   localparam int READERS = 8;
   localparam int IW = 9;          // slot index and count width
   localparam int RW = 3;          // reader index width
   localparam int LW = 16;         // lost counter width
   localparam logic [LW-1:0] LOST_MAX = {LW{1'b1}};

   typedef enum logic [2:0] {
      ACT_RESERVE = 3'd0, ACT_COMMIT = 3'd1, ACT_ADD = 3'd2, ACT_REMOVE = 3'd3,
      ACT_READ_DATA = 3'd4, ACT_READ_COND = 3'd5, ACT_LATEST = 3'd6, ACT_NOP = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_TOO_LARGE = 3'd1, ST_RESERVED = 3'd2, ST_OVER_RES = 3'd3,
      ST_BAD_COUNT = 3'd4, ST_DUP = 3'd5, ST_UNKNOWN = 3'd6, ST_SPARE = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      K_UNUSED = 2'd0, K_PENDING = 2'd1, K_ACTIVE = 2'd2, K_SPARE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INV_WRAP, S_INV_MAIN, S_COMMIT, S_RD1, S_RD2, S_REMOVE, S_DONE
   } state_type;
endpackage
`default_nettype wire

### rtl/multi_reader_ring_index_manager.sv
// Multi-reader ring index manager top level: sequencer and reader table.
// Uses mrrim_pkg.
// Reserve and commit walk the reader table, reserve twice when the block wraps;
// one request is handled at a time.
// The result sits in an output register; the next request is taken once it leaves.
// Synchronous active-high reset: ring empty, no readers, ring_length 256.
`timescale 1ns / 1ps
`default_nettype none
module multi_reader_ring_index_manager
   import mrrim_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [2:0]    req_action,
   input  wire logic [8:0]    req_item_count,
   input  wire logic [2:0]    req_reader_id,
   input  wire logic [1:0]    req_listen_mode,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_first_start,
   output logic [8:0]         rsp_first_count,
   output logic [8:0]         rsp_second_count,
   output logic [15:0]        rsp_lost_count,
   input  wire logic          csr_write,
   input  wire logic [8:0]    csr_data
);
   // state registers
   state_type state_ff;
   logic [IW-1:0] len_cfg_ff, head_ff, vend_ff, resv_ff, latest_ff;
   logic latest_v_ff;
   logic [READERS-1:0] use_ff;
   logic [IW-1:0] dtail_ff [READERS], ctail_ff [READERS];
   kind_type dkind_ff [READERS], ckind_ff [READERS];
   logic [IW-1:0] davl_ff [READERS], cavl_ff [READERS];
   logic [LW-1:0] lost_ff [READERS];
   // request registers
   logic [IW-1:0] cnt_ff;
   logic [RW-1:0] rid_ff;
   logic [RW-1:0] idx_ff;
   logic [IW:0] inv_n_ff;
   logic [IW-1:0] want_ff, got_ff;
   logic part_ff, done_ff;
   logic [2:0] st_ff;
   logic [7:0] fs_ff;
   logic [IW-1:0] c1_ff, c2_ff;
   logic [LW-1:0] lo_ff;

   // ring length in use, held to 1..RING_DEPTH
   logic [IW-1:0] eff_len;
   always_comb begin
      if (len_cfg_ff == '0) eff_len = IW'(1);
      else if (len_cfg_ff > IW'(RING_DEPTH)) eff_len = IW'(RING_DEPTH);
      else eff_len = len_cfg_ff;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign rsp_status = st_ff;
   assign rsp_first_start = fs_ff;
   assign rsp_first_count = c1_ff;
   assign rsp_second_count = c2_ff;
   assign rsp_lost_count = lo_ff;

   // available items for a tail at the present head
   function automatic logic [IW-1:0] avail_f(input logic [IW-1:0] tail,
         input logic [IW-1:0] head, input logic [IW-1:0] vend, input logic more);
      logic [IW:0] v;
      begin
         if (tail == head) v = more ? {1'b0, vend} : '0;
         else if (tail < head) v = {1'b0, head} - {1'b0, tail};
         else v = {1'b0, vend} - {1'b0, tail} + {1'b0, head};
         if (v[IW]) v = '0;
         avail_f = v[IW-1:0];
      end
   endfunction

   // shared per-reader datapath for the walked entry
   logic [IW:0] inv_end, loss_at;
   logic [IW-1:0] new_tail;
   logic [IW:0] dd;
   logic [LW:0] lsum;
   always_comb begin
      inv_end = {1'b0, head_ff} + inv_n_ff;
      loss_at = (inv_end > {1'b0, vend_ff}) ? {1'b0, vend_ff} : inv_end;
      new_tail = (inv_end >= {1'b0, vend_ff}) ? '0 : inv_end[IW-1:0];
      dd = loss_at - {1'b0, dtail_ff[idx_ff]};
      lsum = {1'b0, lost_ff[idx_ff]} + LW'(dd[IW-1:0]);
   end

   // read data pass terms
   logic [IW-1:0] rt, ra;
   logic [IW:0] pass_avl, rem;
   logic pass_done;
   always_comb begin
      rt = dtail_ff[rid_ff];
      ra = davl_ff[rid_ff];
      rem = {1'b0, want_ff} - {1'b0, got_ff};
      pass_done = 1'b0;
      pass_avl = '0;
      if (ra == '0) pass_done = 1'b1;
      else if (rt < head_ff) begin
         pass_avl = {1'b0, head_ff} - {1'b0, rt};
         if (rem < pass_avl) pass_avl = rem;
         pass_done = 1'b1;
      end else begin
         pass_avl = {1'b0, vend_ff} - {1'b0, rt};
         if ({1'b0, want_ff} <= pass_avl) begin
            pass_avl = {1'b0, want_ff};
            pass_done = 1'b1;
         end
      end
      if (pass_avl[IW]) pass_avl = '0;
   end

   logic last_idx;
   assign last_idx = (idx_ff == RW'(READERS - 1));

   // sequencer and table update
   always_ff @(posedge clock) begin
      logic [IW:0] tot;
      logic [IW-1:0] t2;
      logic [IW:0] ca;
      if (reset) begin
         state_ff <= S_IDLE;
         len_cfg_ff <= IW'(RING_DEPTH);
         head_ff <= '0; vend_ff <= '0; resv_ff <= '0; latest_ff <= '0;
         latest_v_ff <= 1'b0; use_ff <= '0; rsp_valid <= 1'b0;
         for (int r = 0; r < READERS; r++) begin
            dtail_ff[r] <= '0; ctail_ff[r] <= '0; davl_ff[r] <= '0; cavl_ff[r] <= '0;
            dkind_ff[r] <= K_UNUSED; ckind_ff[r] <= K_UNUSED; lost_ff[r] <= '0;
         end
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (csr_write) begin
            len_cfg_ff <= csr_data;
            head_ff <= '0; vend_ff <= '0; resv_ff <= '0; latest_ff <= '0;
            latest_v_ff <= 1'b0;
            for (int r = 0; r < READERS; r++) begin
               dtail_ff[r] <= '0; ctail_ff[r] <= '0; davl_ff[r] <= '0; cavl_ff[r] <= '0;
               if (dkind_ff[r] != K_UNUSED) dkind_ff[r] <= K_ACTIVE;
               if (ckind_ff[r] != K_UNUSED) ckind_ff[r] <= K_ACTIVE;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  cnt_ff <= req_item_count; rid_ff <= req_reader_id;
                  idx_ff <= '0;
                  st_ff <= ST_OK; fs_ff <= '0; c1_ff <= '0; c2_ff <= '0; lo_ff <= '0;
                  case (action_type'(req_action))
                     ACT_RESERVE: begin
                        if (req_item_count > eff_len) begin
                           st_ff <= ST_TOO_LARGE; state_ff <= S_DONE;
                        end else if (resv_ff != '0) begin
                           st_ff <= ST_RESERVED; state_ff <= S_DONE;
                        end else if ({1'b0, head_ff} + {1'b0, req_item_count}
                                     > {1'b0, eff_len}) begin
                           inv_n_ff <= {1'b0, eff_len}; state_ff <= S_INV_WRAP;
                        end else begin
                           inv_n_ff <= {1'b0, req_item_count}; state_ff <= S_INV_MAIN;
                        end
                     end
                     ACT_COMMIT: begin
                        tot = {1'b0, head_ff} + {1'b0, req_item_count};
                        if (req_item_count > resv_ff) begin
                           st_ff <= ST_OVER_RES; state_ff <= S_DONE;
                        end else if (tot > {1'b0, eff_len}) begin
                           st_ff <= ST_BAD_COUNT; resv_ff <= '0; state_ff <= S_DONE;
                        end else if (req_item_count == '0) begin
                           resv_ff <= '0; state_ff <= S_DONE;
                        end else begin
                           latest_ff <= tot[IW-1:0] - IW'(1); latest_v_ff <= 1'b1;
                           if ({1'b0, vend_ff} < tot) vend_ff <= tot[IW-1:0];
                           head_ff <= (tot == {1'b0, eff_len}) ? '0 : tot[IW-1:0];
                           resv_ff <= '0; state_ff <= S_COMMIT;
                        end
                     end
                     ACT_ADD: begin
                        if (use_ff[req_reader_id]) st_ff <= ST_DUP;
                        else begin
                           use_ff[req_reader_id] <= 1'b1;
                           dkind_ff[req_reader_id] <= K_UNUSED;
                           ckind_ff[req_reader_id] <= K_UNUSED;
                           dtail_ff[req_reader_id] <= '0; ctail_ff[req_reader_id] <= '0;
                           davl_ff[req_reader_id] <= '0; cavl_ff[req_reader_id] <= '0;
                           lost_ff[req_reader_id] <= '0;
                           if (req_listen_mode == 2'd0) begin
                              if (resv_ff != '0) dkind_ff[req_reader_id] <= K_PENDING;
                              else begin
                                 dtail_ff[req_reader_id] <= head_ff;
                                 dkind_ff[req_reader_id] <= K_ACTIVE;
                              end
                           end else if (req_listen_mode == 2'd1) begin
                              ctail_ff[req_reader_id] <= head_ff;
                              ckind_ff[req_reader_id] <= K_ACTIVE;
                           end
                        end
                        state_ff <= S_DONE;
                     end
                     ACT_REMOVE: begin
                        if (!use_ff[req_reader_id]) st_ff <= ST_UNKNOWN;
                        else begin
                           use_ff[req_reader_id] <= 1'b0;
                           dkind_ff[req_reader_id] <= K_UNUSED;
                           ckind_ff[req_reader_id] <= K_UNUSED;
                           davl_ff[req_reader_id] <= '0; cavl_ff[req_reader_id] <= '0;
                           lost_ff[req_reader_id] <= '0;
                        end
                        state_ff <= S_REMOVE;
                     end
                     ACT_READ_DATA: begin
                        if (!use_ff[req_reader_id]) begin
                           st_ff <= ST_UNKNOWN; state_ff <= S_DONE;
                        end else begin
                           lo_ff <= lost_ff[req_reader_id];
                           lost_ff[req_reader_id] <= '0;
                           if (dkind_ff[req_reader_id] == K_ACTIVE) begin
                              want_ff <= (req_item_count < davl_ff[req_reader_id]) ?
                                         req_item_count : davl_ff[req_reader_id];
                              got_ff <= '0; part_ff <= 1'b0; done_ff <= 1'b0;
                              fs_ff <= dtail_ff[req_reader_id][7:0];
                              state_ff <= S_RD1;
                           end else begin
                              if (dkind_ff[req_reader_id] == K_PENDING) begin
                                 dtail_ff[req_reader_id] <= head_ff;
                                 davl_ff[req_reader_id] <= '0;
                                 dkind_ff[req_reader_id] <= K_ACTIVE;
                              end
                              if (ckind_ff[req_reader_id] == K_ACTIVE)
                                 cavl_ff[req_reader_id] <= avail_f(ctail_ff[req_reader_id],
                                    head_ff, vend_ff, 1'b0);
                              state_ff <= S_DONE;
                           end
                        end
                     end
                     ACT_READ_COND: begin
                        if (!use_ff[req_reader_id]) st_ff <= ST_UNKNOWN;
                        else if (ckind_ff[req_reader_id] == K_ACTIVE) begin
                           t2 = ctail_ff[req_reader_id];
                           fs_ff <= t2[7:0];
                           if (cavl_ff[req_reader_id] != '0) begin
                              if (t2 >= head_ff) begin
                                 ca = {1'b0, vend_ff} - {1'b0, t2};
                                 c1_ff <= ca[IW] ? '0 : ca[IW-1:0];
                                 c2_ff <= head_ff;
                              end else c1_ff <= head_ff - t2;
                           end
                           ctail_ff[req_reader_id] <= head_ff;
                           cavl_ff[req_reader_id] <= '0;
                        end
                        state_ff <= S_DONE;
                     end
                     ACT_LATEST: begin
                        if (latest_v_ff) begin
                           fs_ff <= latest_ff[7:0]; c1_ff <= IW'(1);
                        end
                        state_ff <= S_DONE;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            // one reader per cycle: move overrun tails past the block
            S_INV_WRAP, S_INV_MAIN: begin
               if (use_ff[idx_ff]) begin
                  logic [IW-1:0] dt, ct;
                  kind_type dk, ck;
                  logic hit;
                  dt = dtail_ff[idx_ff]; ct = ctail_ff[idx_ff];
                  dk = dkind_ff[idx_ff]; ck = ckind_ff[idx_ff];
                  hit = 1'b0;
                  if (dk == K_ACTIVE && davl_ff[idx_ff] != '0 && dt >= head_ff &&
                      {1'b0, dt} < inv_end) begin
                     if (!dd[IW] && dd != '0)
                        lost_ff[idx_ff] <= lsum[LW] ? LOST_MAX : lsum[LW-1:0];
                     dt = new_tail; hit = 1'b1;
                     if (ck == K_PENDING) ck = K_ACTIVE;
                  end
                  if (ck == K_ACTIVE && cavl_ff[idx_ff] != '0 && ct >= head_ff &&
                      {1'b0, ct} < inv_end) begin
                     ct = new_tail; hit = 1'b1;
                  end
                  if (hit) begin
                     dtail_ff[idx_ff] <= dt; ctail_ff[idx_ff] <= ct;
                     if (dk == K_ACTIVE)
                        davl_ff[idx_ff] <= avail_f(dt, head_ff, vend_ff, 1'b0);
                     else if (dk == K_PENDING) begin
                        dtail_ff[idx_ff] <= head_ff; davl_ff[idx_ff] <= '0;
                        dkind_ff[idx_ff] <= K_ACTIVE;
                     end
                     if (ckind_ff[idx_ff] == K_ACTIVE)
                        cavl_ff[idx_ff] <= avail_f(ct, head_ff, vend_ff, 1'b0);
                     else if (ckind_ff[idx_ff] == K_PENDING) begin
                        ctail_ff[idx_ff] <= head_ff; cavl_ff[idx_ff] <= '0;
                        ckind_ff[idx_ff] <= K_ACTIVE;
                     end
                  end
               end
               idx_ff <= idx_ff + RW'(1);
               if (last_idx) begin
                  if (inv_end >= {1'b0, vend_ff}) vend_ff <= head_ff;
                  idx_ff <= '0;
                  if (state_ff == S_INV_WRAP) begin
                     head_ff <= '0; inv_n_ff <= {1'b0, cnt_ff};
                     state_ff <= S_INV_MAIN;
                  end else begin
                     resv_ff <= cnt_ff; fs_ff <= head_ff[7:0];
                     state_ff <= S_DONE;
                  end
               end
            end
            // refresh every reader in use after a commit
            S_COMMIT: begin
               if (use_ff[idx_ff]) begin
                  if (dkind_ff[idx_ff] == K_PENDING) begin
                     dtail_ff[idx_ff] <= head_ff; davl_ff[idx_ff] <= '0;
                     dkind_ff[idx_ff] <= K_ACTIVE;
                  end else if (dkind_ff[idx_ff] == K_ACTIVE)
                     davl_ff[idx_ff] <= avail_f(dtail_ff[idx_ff], head_ff, vend_ff, 1'b1);
                  if (ckind_ff[idx_ff] == K_PENDING) begin
                     ctail_ff[idx_ff] <= head_ff; cavl_ff[idx_ff] <= '0;
                     ckind_ff[idx_ff] <= K_ACTIVE;
                  end else if (ckind_ff[idx_ff] == K_ACTIVE)
                     cavl_ff[idx_ff] <= avail_f(ctail_ff[idx_ff], head_ff, vend_ff, 1'b1);
               end
               idx_ff <= idx_ff + RW'(1);
               if (last_idx) state_ff <= S_DONE;
            end
            S_REMOVE: begin
               if (use_ff == '0) resv_ff <= '0;
               state_ff <= S_DONE;
            end
            // data read: up to two passes
            S_RD1, S_RD2: begin
               if (done_ff) state_ff <= S_DONE;
               else begin
                  logic [IW-1:0] nt;
                  nt = rt + pass_avl[IW-1:0];
                  got_ff <= got_ff + pass_avl[IW-1:0];
                  if (!part_ff) c1_ff <= c1_ff + pass_avl[IW-1:0];
                  else c2_ff <= c2_ff + pass_avl[IW-1:0];
                  if (nt == vend_ff && vend_ff != head_ff) begin
                     nt = '0; part_ff <= 1'b1;
                  end
                  dtail_ff[rid_ff] <= nt;
                  davl_ff[rid_ff] <= avail_f(nt, head_ff, vend_ff, 1'b0);
                  if (ckind_ff[rid_ff] == K_ACTIVE)
                     cavl_ff[rid_ff] <= avail_f(ctail_ff[rid_ff], head_ff, vend_ff, 1'b0);
                  done_ff <= pass_done;
                  state_ff <= (state_ff == S_RD1) ? S_RD2 : S_DONE;
               end
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE)) else $error("ready while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE)) else $error("stray response");
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && last_idx) |=> (state_ff == S_DONE))
      else $error("commit walk did not end");
endmodule
`default_nettype wire
